@@ rtl/core/bps_pkg.sv @@
package bps_pkg;

  // Register and field widths
  localparam int unsigned REG_W      = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned BLINK_W    = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration reset values
  localparam logic [REG_W-1:0] HOLD_LIMIT_RST      = 8'd10;
  localparam logic [REG_W-1:0] EMPTY_LIMIT_RST     = 8'd5;
  localparam logic [REG_W-1:0] REPORT_INTERVAL_RST = 8'd20;

  // Blink phase on which the LED toggles, and empty counter ceiling
  localparam logic [BLINK_W-1:0] BLINK_TOGGLE = 2'd3;
  localparam logic [REG_W-1:0]   EMPTY_MAX    = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HOLD_LIMIT      = 2'd0,
    CFG_EMPTY_LIMIT     = 2'd1,
    CFG_REPORT_INTERVAL = 2'd2
  } cfg_idx_t;

  // Request kinds
  typedef enum logic {
    REQ_TICK     = 1'b0,
    REQ_HOST_CMD = 1'b1
  } req_t;

  typedef struct packed {
    logic [REG_W-1:0] hold_limit;
    logic [REG_W-1:0] empty_limit;
    logic [REG_W-1:0] report_interval;
  } cfg_t;

  typedef struct packed {
    req_t req_type;
    logic button_level;
    logic battery_empty;
    logic vbus_absent;
    logic power_good_level;
    logic command_pending;
    logic host_load_value;
  } in_item_t;

  typedef struct packed {
    logic power_off;
    logic led_on;
    logic load_enable;
    logic report_due;
    logic serve_command;
  } out_item_t;

endpackage

@@ rtl/core/bps_step.sv @@
module bps_step import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic               button_held_r, button_held_nxt;
  logic [REG_W-1:0]   hold_count_r, hold_count_nxt;
  logic [REG_W-1:0]   empty_count_r, empty_count_nxt;
  logic [BLINK_W-1:0] blink_phase_r, blink_phase_nxt;
  logic               led_level_r, led_level_nxt;
  logic [REG_W-1:0]   report_count_r, report_count_nxt;
  logic               good_history_r, good_history_nxt;
  logic               load_level_r, load_level_nxt;
  logic               host_override_r, host_override_nxt;

  logic pressed;
  logic empty_no_vbus;
  logic off;
  logic report;

  assign pressed       = ~item.button_level;
  assign empty_no_vbus = item.battery_empty & item.vbus_absent;

  // Compute next state and the result for one transaction
  always_comb begin
    button_held_nxt   = button_held_r;
    hold_count_nxt    = hold_count_r;
    empty_count_nxt   = empty_count_r;
    blink_phase_nxt   = blink_phase_r;
    led_level_nxt     = led_level_r;
    report_count_nxt  = report_count_r;
    good_history_nxt  = good_history_r;
    load_level_nxt    = load_level_r;
    host_override_nxt = host_override_r;
    off               = 1'b0;
    report            = 1'b0;

    if (item.req_type == REQ_HOST_CMD) begin
      host_override_nxt = item.host_load_value;
      load_level_nxt    = item.host_load_value;
    end else begin
      // Power button hold
      if (pressed && !button_held_r) begin
        button_held_nxt = 1'b1;
        hold_count_nxt  = hold_count_r + 1'b1;
      end else if (pressed) begin
        if (hold_count_r >= cfg.hold_limit) begin
          hold_count_nxt = '0;
          off            = 1'b1;
        end else begin
          hold_count_nxt = hold_count_r + 1'b1;
        end
      end else if (button_held_r) begin
        hold_count_nxt  = '0;
        button_held_nxt = 1'b0;
      end

      // Empty battery without VBUS, saturating count
      if (empty_no_vbus) begin
        if (empty_count_r != EMPTY_MAX) empty_count_nxt = empty_count_r + 1'b1;
        if (empty_count_r > cfg.empty_limit) off = 1'b1;
      end else begin
        empty_count_nxt = '0;
      end

      // LED blink while empty
      if (item.battery_empty && (blink_phase_r == BLINK_TOGGLE)) begin
        led_level_nxt = ~led_level_r;
      end else if (!item.battery_empty) begin
        led_level_nxt = 1'b1;
      end
      blink_phase_nxt = blink_phase_r + 1'b1;

      // Report pacing
      if (report_count_r < cfg.report_interval) begin
        report_count_nxt = report_count_r + 1'b1;
      end else begin
        report_count_nxt = '0;
        report           = 1'b1;
      end

      // Load switch follows power-good edges unless the host holds it
      if (!host_override_r) begin
        if (!item.power_good_level && !good_history_r) begin
          good_history_nxt = 1'b1;
          load_level_nxt   = 1'b0;
        end else if (item.power_good_level && good_history_r) begin
          good_history_nxt = 1'b0;
          load_level_nxt   = 1'b1;
        end
      end
    end

    result.power_off     = off;
    result.led_on        = led_level_nxt;
    result.load_enable   = load_level_nxt;
    result.report_due    = report;
    result.serve_command = ~report & item.command_pending &
                           (item.req_type == REQ_TICK);
  end

  // Advance state on each processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_held_r   <= 1'b0;
      hold_count_r    <= '0;
      empty_count_r   <= '0;
      blink_phase_r   <= '0;
      led_level_r     <= 1'b1;
      report_count_r  <= '0;
      good_history_r  <= 1'b1;
      load_level_r    <= 1'b0;
      host_override_r <= 1'b0;
    end else if (step_en) begin
      button_held_r   <= button_held_nxt;
      hold_count_r    <= hold_count_nxt;
      empty_count_r   <= empty_count_nxt;
      blink_phase_r   <= blink_phase_nxt;
      led_level_r     <= led_level_nxt;
      report_count_r  <= report_count_nxt;
      good_history_r  <= good_history_nxt;
      load_level_r    <= load_level_nxt;
      host_override_r <= host_override_nxt;
    end
  end

endmodule

@@ rtl/core/battery_power_supervisor_tick_top.sv @@
// A transaction accepted at in_* is held in the input register, then passes through one
// step of the supervisor logic into the result register, which drives out_*.
// Throughput: one transaction per clock while out_tready stays high.
// Reset (rst_n low at a clock edge) empties both registers, loads the
// configuration defaults and returns all supervisor state to its start values.
module battery_power_supervisor_tick_top import bps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] button_level, [1] battery_empty, [2] vbus_absent,
  // [3] power_good_level, [4] command_pending, [5] host_load_value, [7:6] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                  in_tuser,
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] power_off, [1] led_on, [2] load_enable, [3] report_due,
  // [4] serve_command, [7:5] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  in_item_t  in_item;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      out_free;
  logic      step_fire;

  // Unpack the input transaction
  assign in_item.req_type         = req_t'(in_tuser);
  assign in_item.button_level     = in_tdata[0];
  assign in_item.battery_empty    = in_tdata[1];
  assign in_item.vbus_absent      = in_tdata[2];
  assign in_item.power_good_level = in_tdata[3];
  assign in_item.command_pending  = in_tdata[4];
  assign in_item.host_load_value  = in_tdata[5];

  assign out_free  = ~out_valid_r | out_tready;
  assign step_fire = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_limit      <= HOLD_LIMIT_RST;
      cfg_r.empty_limit     <= EMPTY_LIMIT_RST;
      cfg_r.report_interval <= REPORT_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HOLD_LIMIT:      cfg_r.hold_limit      <= cfg_wdata;
        CFG_EMPTY_LIMIT:     cfg_r.empty_limit     <= cfg_wdata;
        CFG_REPORT_INTERVAL: cfg_r.report_interval <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_item_r <= in_item;
  end

  bps_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_fire),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) out_item_r <= step_result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_item_r.serve_command, out_item_r.report_due,
                       out_item_r.load_enable, out_item_r.led_on,
                       out_item_r.power_off};

  // A report tick never serves a command
  a_report_serve_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[4]))
    else $error("report_due and serve_command both set");

  // A host command result carries no pulses
  a_host_cmd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && (s1_item_r.req_type == REQ_HOST_CMD)) |=>
      (!out_tdata[0] && !out_tdata[3] && !out_tdata[4]))
    else $error("host command result has a pulse set");

  // A held item moves to the result register once it is free
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input register item not advanced");

  // Input side always takes a transaction when the input register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty input register");

endmodule

@@ sim/supervisor_checker.sv @@
module supervisor_checker
  import bps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata,
  output int                    mismatches,
  output int                    awaiting,
  output int                    compared,
  output int                    off_pulses,
  output int                    reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration and the supervisor state
  cfg_t               regs;
  logic               button_held;
  logic [REG_W-1:0]   hold_count;
  logic [REG_W-1:0]   empty_count;
  logic [BLINK_W-1:0] blink_phase;
  logic               led_level;
  logic [REG_W-1:0]   report_count;
  logic               good_history;
  logic               load_level;
  logic               host_override;

  out_item_t expected_outputs[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic reset_state();
    regs.hold_limit      = HOLD_LIMIT_RST;
    regs.empty_limit     = EMPTY_LIMIT_RST;
    regs.report_interval = REPORT_INTERVAL_RST;
    button_held   = 1'b0;
    hold_count    = '0;
    empty_count   = '0;
    blink_phase   = '0;
    led_level     = 1'b1;
    report_count  = '0;
    good_history  = 1'b1;
    load_level    = 1'b0;
    host_override = 1'b0;
    expected_outputs.delete();
    mismatches   = 0;
    compared     = 0;
    off_pulses   = 0;
    reports_seen = 0;
  endtask

  // Advance the supervisor by one transaction and return its result
  function automatic out_item_t supervise_step(input in_item_t it);
    out_item_t        r;
    logic [REG_W-1:0] prior;
    r = '0;
    if (it.req_type == REQ_HOST_CMD) begin
      host_override = it.host_load_value;
      load_level    = it.host_load_value;
    end else begin
      // power button, pressed when the level is low
      if (!it.button_level && !button_held) begin
        button_held = 1'b1;
        hold_count  = hold_count + 1'b1;
      end else if (!it.button_level) begin
        prior      = hold_count;
        hold_count = hold_count + 1'b1;
        if (prior >= regs.hold_limit) begin
          hold_count  = '0;
          r.power_off = 1'b1;
        end
      end else if (button_held) begin
        hold_count  = '0;
        button_held = 1'b0;
      end

      // empty battery without VBUS, counter saturates
      if (it.battery_empty && it.vbus_absent) begin
        prior = empty_count;
        if (empty_count != EMPTY_MAX) empty_count = empty_count + 1'b1;
        if (prior > regs.empty_limit) r.power_off = 1'b1;
      end else begin
        empty_count = '0;
      end

      // LED blinks while empty, steady on otherwise
      if (it.battery_empty && blink_phase == BLINK_TOGGLE) led_level = ~led_level;
      else if (!it.battery_empty) led_level = 1'b1;
      blink_phase = blink_phase + 1'b1;

      // report pacing, commands served on the other ticks
      if (report_count < regs.report_interval) begin
        report_count = report_count + 1'b1;
      end else begin
        report_count = '0;
        r.report_due = 1'b1;
      end
      r.serve_command = !r.report_due && it.command_pending;

      // load follows power-good edges unless the host has taken it over
      if (!host_override) begin
        if (!it.power_good_level && !good_history) begin
          good_history = 1'b1;
          load_level   = 1'b0;
        end else if (it.power_good_level && good_history) begin
          good_history = 1'b0;
          load_level   = 1'b1;
        end
      end
    end
    r.led_on      = led_level;
    r.load_enable = load_level;
    return r;
  endfunction

  task automatic field_check(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %b expected %b in result %0d", name, got, want,
                                compared));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_outputs.size() == 0) begin
      report_mismatch($sformatf("result %b arrived with nothing outstanding", got));
    end else begin
      want = expected_outputs.pop_front();
      field_check("power_off", got.power_off, want.power_off);
      field_check("led_on", got.led_on, want.led_on);
      field_check("load_enable", got.load_enable, want.load_enable);
      field_check("report_due", got.report_due, want.report_due);
      field_check("serve_command", got.serve_command, want.serve_command);
      if (want.power_off) off_pulses++;
      if (want.report_due) reports_seen++;
      compared++;
    end
  endtask

  // Watch register writes and both channels at each rising edge
  always @(posedge clk) begin
    in_item_t  it;
    out_item_t got;
    if (!rst_n) begin
      reset_state();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_HOLD_LIMIT:      regs.hold_limit      = cfg_wdata;
          CFG_EMPTY_LIMIT:     regs.empty_limit     = cfg_wdata;
          CFG_REPORT_INTERVAL: regs.report_interval = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.power_off     = out_tdata[0];
        got.led_on        = out_tdata[1];
        got.load_enable   = out_tdata[2];
        got.report_due    = out_tdata[3];
        got.serve_command = out_tdata[4];
        check_result(got);
      end
      if (in_tvalid && in_tready) begin
        it.req_type         = req_t'(in_tuser);
        it.button_level     = in_tdata[0];
        it.battery_empty    = in_tdata[1];
        it.vbus_absent      = in_tdata[2];
        it.power_good_level = in_tdata[3];
        it.command_pending  = in_tdata[4];
        it.host_load_value  = in_tdata[5];
        expected_outputs.push_back(supervise_step(it));
      end
    end
    awaiting = expected_outputs.size();
  end

endmodule

@@ sim/battery_power_supervisor_tick_top_tb.sv @@
module battery_power_supervisor_tick_top_tb import bps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 4;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 96;
  // index with no register behind it
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [0] button_level, [1] battery_empty, [2] vbus_absent,
  // [3] power_good_level, [4] command_pending, [5] host_load_value, [7:6] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [0] req_type
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] power_off, [1] led_on, [2] load_enable, [3] report_due,
  // [4] serve_command, [7:5] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [REG_W-1:0]      cfg_wdata  = '0;

  int mismatches, awaiting, compared, off_pulses, reports_seen;

  logic             hold_off_req = 1'b0;
  int unsigned      quiet        = 0;
  int               burst_left   = 0;
  int               press_left   = 0;
  int               empty_left   = 0;
  logic             pg_level     = 1'b1;
  logic [REG_W-1:0] cur_hold     = HOLD_LIMIT_RST;
  logic [REG_W-1:0] cur_empty    = EMPTY_LIMIT_RST;
  int               items_sent   = 0;
  int               host_cmds    = 0;
  int               settings     = 1;

  battery_power_supervisor_tick_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  supervisor_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .compared     (compared),
    .off_pulses   (off_pulses),
    .reports_seen (reports_seen)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, awaiting);
      $display("battery_power_supervisor_tick_top_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: rotate through ready patterns, honor a long hold-off on request
  initial begin : receiver
    int unsigned tick;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        case ((tick / 48) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= (tick % 4) != 3;
          2:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(input req_t kind, input logic btn, input logic empty,
                                         input logic novbus, input logic pg, input logic pend,
                                         input logic host);
    in_item_t it;
    it.req_type         = kind;
    it.button_level     = btn;
    it.battery_empty    = empty;
    it.vbus_absent      = novbus;
    it.power_good_level = pg;
    it.command_pending  = pend;
    it.host_load_value  = host;
    return it;
  endfunction

  // Random content on top of button-press and empty-battery runs
  function automatic in_item_t random_item();
    in_item_t it;
    int       span;
    if (press_left == 0 && $urandom_range(0, 15) == 0) begin
      span = (cur_hold > 40) ? 40 : cur_hold;
      press_left = $urandom_range(1, span + 4);
    end
    if (empty_left == 0 && $urandom_range(0, 15) == 0) begin
      span = (cur_empty > 40) ? 40 : cur_empty;
      empty_left = $urandom_range(1, span + 6);
    end
    // break a short run now and then
    if (press_left < 50 && $urandom_range(0, 29) == 0) press_left = 0;
    if (empty_left < 50 && $urandom_range(0, 29) == 0) empty_left = 0;
    if ($urandom_range(0, 5) == 0) pg_level = ~pg_level;
    it.req_type         = ($urandom_range(0, 9) == 0) ? REQ_HOST_CMD : REQ_TICK;
    it.button_level     = (press_left != 0) ? 1'b0 : ($urandom_range(0, 7) != 0);
    it.battery_empty    = (empty_left != 0) ? 1'b1 : ($urandom_range(0, 5) == 0);
    it.vbus_absent      = (empty_left != 0) ? 1'b1 : 1'($urandom_range(0, 1));
    it.power_good_level = pg_level;
    it.command_pending  = 1'($urandom_range(0, 1));
    it.host_load_value  = 1'($urandom_range(0, 1));
    if (it.req_type == REQ_TICK) begin
      if (press_left != 0) press_left--;
      if (empty_left != 0) empty_left--;
    end
    return it;
  endfunction

  // Offer one transaction in bursts with random gaps, hold until accepted
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {2'b00, it.host_load_value, it.command_pending, it.power_good_level,
                  it.vbus_absent, it.battery_empty, it.button_level};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (it.req_type == REQ_HOST_CMD) host_cmds++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (awaiting != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [REG_W-1:0] hold, input logic [REG_W-1:0] empty,
                           input logic [REG_W-1:0] interval);
    write_reg(CFG_HOLD_LIMIT, hold);
    write_reg(CFG_EMPTY_LIMIT, empty);
    write_reg(CFG_REPORT_INTERVAL, interval);
    write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    cfg_we    <= 1'b0;
    cur_hold  = hold;
    cur_empty = empty;
    settings++;
  endtask

  task automatic random_phase(input int count, input int press_run, input int empty_run);
    press_left = press_run;
    empty_left = empty_run;
    repeat (count) send(random_item());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start-up load, power-good edges and host override at reset settings
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send(make_item(REQ_HOST_CMD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send(make_item(REQ_HOST_CMD, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    drain();

    // short limits: button hold fires, empty run fires and blinks, report pacing
    configure(8'd2, 8'd1, 8'd2);
    repeat (5) send(make_item(REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    repeat (7) send(make_item(REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send(make_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    drain();

    // long receiver hold-off while the sender keeps offering
    configure(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
              8'($urandom_range(0, 12)));
    @(negedge clk) hold_off_req = 1'b1;
    @(posedge clk);
    random_phase(80, 0, 0);

    configure(8'd0, 8'd0, 8'd0);
    random_phase(80, 0, 0);

    // top limits: the empty counter runs to saturation, empty limit of 255 never fires
    configure(8'd255, 8'd255, 8'd255);
    random_phase(300, 270, 270);

    // empty limit 254 fires only once the counter has saturated
    configure(8'd3, 8'd254, 8'd7);
    random_phase(290, 0, 270);

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 30)),
              8'($urandom_range(0, 30)));
    random_phase(80, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    $display("covered %0d transactions (%0d host commands) over %0d register settings",
             items_sent, host_cmds, settings);
    $display("compared %0d results with %0d power-off pulses and %0d status reports",
             compared, off_pulses, reports_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("battery_power_supervisor_tick_top_tb: PASS");
    end else begin
      $display("battery_power_supervisor_tick_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bps_pkg.sv
rtl/core/bps_step.sv
rtl/core/battery_power_supervisor_tick_top.sv
sim/supervisor_checker.sv
sim/battery_power_supervisor_tick_top_tb.sv
